/* hw/rtl/bba_pkg.sv */
`default_nettype none

package bba_pkg;

  // Pool size used when the top level is not overridden.
  localparam int unsigned LEAVES_DEFAULT = 1024;

  // Fixed field widths of the transaction payloads.
  localparam int unsigned SIZE_W = 11;
  localparam int unsigned OFF_W  = 10;

  typedef enum logic [0:0] {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } bba_cmd_e;

  typedef enum logic [1:0] {
    STAT_DONE     = 2'd0,
    STAT_NO_SPACE = 2'd1,
    STAT_BAD_FREE = 2'd2
  } bba_status_e;

  typedef struct packed {
    bba_cmd_e          command;
    logic [SIZE_W-1:0] size_blocks;
    logic [OFF_W-1:0]  offset;
  } bba_in_t;

  typedef struct packed {
    logic [OFF_W-1:0] block_offset;
    bba_status_e      status;
  } bba_out_t;

  // Decision flags from the shared node unit.
  typedef struct packed {
    logic take_left;
    logic buddies_free;
  } bba_cmp_t;

endpackage

`default_nettype wire

/* hw/rtl/bba_tree_mem.sv */
`default_nettype none

module bba_tree_mem #(
  parameter int unsigned LEAVES = bba_pkg::LEAVES_DEFAULT
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [$clog2(LEAVES):0]     rd_a_addr_i,
  input  wire logic [$clog2(LEAVES):0]     rd_b_addr_i,
  output logic      [$clog2(LEAVES):0]     rd_a_data_o,
  output logic      [$clog2(LEAVES):0]     rd_b_data_o,
  input  wire logic                        wr_en_i,
  input  wire logic [$clog2(LEAVES):0]     wr_addr_i,
  input  wire logic [$clog2(LEAVES):0]     wr_data_i,
  output logic                             busy_o
);

  localparam int unsigned LW    = $clog2(LEAVES);
  localparam int unsigned NW    = LW + 1;
  localparam int unsigned VW    = LW + 1;
  localparam int unsigned NODES = 2 * LEAVES - 1;

  logic [VW-1:0] tree_q [NODES];
  logic [VW-1:0] rd_a_q, rd_b_q;

  logic          busy_q, busy_d;
  logic [NW-1:0] init_idx_q, init_idx_d;
  logic [NW-1:0] init_bound_q, init_bound_d;
  logic [VW-1:0] init_val_q, init_val_d;

  logic          we;
  logic [NW-1:0] wa;
  logic [VW-1:0] wd;

  // The clearing pass owns the write port until every node holds its reset value.
  assign we = busy_q | wr_en_i;
  assign wa = busy_q ? init_idx_q : wr_addr_i;
  assign wd = busy_q ? init_val_q : wr_data_i;

  // Sweep one node per cycle; the value halves after the last node of each level.
  always_comb begin
    busy_d       = busy_q;
    init_idx_d   = init_idx_q;
    init_bound_d = init_bound_q;
    init_val_d   = init_val_q;
    if (busy_q) begin
      init_idx_d = init_idx_q + NW'(1);
      if (init_idx_q == NW'(NODES - 1)) begin
        busy_d = 1'b0;
      end
      if (init_idx_q == init_bound_q) begin
        init_val_d   = init_val_q >> 1;
        init_bound_d = NW'({init_bound_q, 1'b0} + (NW + 1)'(2));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b1;
      init_idx_q   <= '0;
      init_bound_q <= '0;
      init_val_q   <= VW'(LEAVES);
    end else begin
      busy_q       <= busy_d;
      init_idx_q   <= init_idx_d;
      init_bound_q <= init_bound_d;
      init_val_q   <= init_val_d;
    end
  end

  // One write port and two registered read ports.
  always_ff @(posedge clk_i) begin
    if (we) begin
      tree_q[wa] <= wd;
    end
    rd_a_q <= tree_q[rd_a_addr_i];
    rd_b_q <= tree_q[rd_b_addr_i];
  end

  assign rd_a_data_o = rd_a_q;
  assign rd_b_data_o = rd_b_q;
  assign busy_o      = busy_q;

endmodule

`default_nettype wire

/* hw/rtl/bba_node_unit.sv */
`default_nettype none

module bba_node_unit #(
  parameter int unsigned LEAVES = bba_pkg::LEAVES_DEFAULT
) (
  input  wire logic [$clog2(LEAVES):0] left_i,
  input  wire logic [$clog2(LEAVES):0] right_i,
  input  wire logic [$clog2(LEAVES):0] want_i,
  input  wire logic [$clog2(LEAVES):0] node_size_i,
  input  wire logic                    merge_en_i,
  output bba_pkg::bba_cmp_t            flags_o,
  output logic      [$clog2(LEAVES):0] value_o
);

  localparam int unsigned VW = $clog2(LEAVES) + 1;

  logic [VW:0]   pair_sum;
  logic [VW-1:0] larger;

  // Descent choice: left unless the right child fits and the left one does not fit or is larger.
  assign flags_o.take_left = (right_i < want_i) || ((want_i <= left_i) && (left_i <= right_i));

  // Two entirely free buddies merge into one run of the parent's size.
  assign pair_sum             = {1'b0, left_i} + {1'b0, right_i};
  assign flags_o.buddies_free = merge_en_i && (pair_sum == {1'b0, node_size_i});

  assign larger  = (left_i > right_i) ? left_i : right_i;
  assign value_o = flags_o.buddies_free ? node_size_i : larger;

endmodule

`default_nettype wire

/* hw/rtl/buddy_block_allocator_core.sv */
// Allocate: from the root one tree level per cycle down to a node of the rounded size, and
// one back up to the root; larger runs stop the descent sooner.
// Free: climbs from the leaf to the allocated node, then on up to the root.
// One transaction at a time: the next is accepted the cycle after the result is registered,
// and a result waits in S_RESP while an earlier one is still stalled at the output. After
// reset a clearing pass loads the tree, and no request is accepted until it ends.
`default_nettype none

module buddy_block_allocator_core #(
  parameter int unsigned LEAVES = bba_pkg::LEAVES_DEFAULT
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire bba_pkg::bba_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output bba_pkg::bba_out_t      out_data_o
);

  localparam int unsigned LW   = $clog2(LEAVES);
  localparam int unsigned NW   = LW + 1;
  localparam int unsigned VW   = LW + 1;
  localparam int unsigned OffW = bba_pkg::OFF_W;
  localparam int unsigned SzW  = bba_pkg::SIZE_W;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_AROOT  = 6'b000010,
    S_ADOWN  = 6'b000100,
    S_UP     = 6'b001000,
    S_FCLIMB = 6'b010000,
    S_RESP   = 6'b100000
  } bba_state_e;

  bba_state_e           state_q, state_d;
  bba_pkg::bba_cmd_e    cmd_q, cmd_d;
  logic [VW-1:0]        want_q, want_d;
  logic [VW-1:0]        nodesize_q, nodesize_d;
  logic [NW-1:0]        node_q, node_d;
  logic [LW-1:0]        off_q, off_d;
  logic                 side_q, side_d;
  logic [VW-1:0]        wval_q, wval_d;
  logic [LW-1:0]        res_off_q, res_off_d;
  bba_pkg::bba_status_e res_status_q, res_status_d;
  logic                 out_valid_q;
  bba_pkg::bba_out_t    out_q;

  logic          mem_busy;
  logic [NW-1:0] rd_a_addr, rd_b_addr, wr_addr;
  logic [VW-1:0] rd_a_data, rd_b_data, wr_data;
  logic          wr_en;

  logic              unit_merge;
  logic [VW-1:0]     unit_lv, unit_rv, unit_value;
  bba_pkg::bba_cmp_t unit_flags;

  logic          in_accept, out_free;
  logic [SzW:0]  req_want;
  logic          size_too_big, off_bad;
  logic [NW-1:0] leaf_idx, child, lo_kid;
  logic [VW-1:0] half;

  // Smallest power of two at or above the request, with zero counted as one.
  function automatic logic [SzW:0] round_pow2(logic [SzW-1:0] size);
    logic [SzW-1:0] x;
    x = (size == '0) ? '0 : size - SzW'(1);
    x = x | (x >> 1);
    x = x | (x >> 2);
    x = x | (x >> 4);
    x = x | (x >> 8);
    return {1'b0, x} + (SzW + 1)'(1);
  endfunction

  function automatic logic [NW-1:0] parent_of(logic [NW-1:0] n);
    return (n - NW'(1)) >> 1;
  endfunction

  // Left member of the buddy pair that contains node n.
  function automatic logic [NW-1:0] pair_lo(logic [NW-1:0] n);
    return (n - NW'(1)) | NW'(1);
  endfunction

  function automatic logic [NW-1:0] left_kid(logic [NW-1:0] n);
    return NW'({n, 1'b1});
  endfunction

  bba_tree_mem #(
    .LEAVES(LEAVES)
  ) u_mem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_a_addr_i (rd_a_addr),
    .rd_b_addr_i (rd_b_addr),
    .rd_a_data_o (rd_a_data),
    .rd_b_data_o (rd_b_data),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (wr_data),
    .busy_o      (mem_busy)
  );

  // On the way up, the child written last cycle comes from its register, not the memory.
  assign unit_lv    = (state_q == S_UP && !side_q) ? wval_q : rd_a_data;
  assign unit_rv    = (state_q == S_UP &&  side_q) ? wval_q : rd_b_data;
  assign unit_merge = (cmd_q == bba_pkg::CMD_FREE);

  bba_node_unit #(
    .LEAVES(LEAVES)
  ) u_unit (
    .left_i      (unit_lv),
    .right_i     (unit_rv),
    .want_i      (want_q),
    .node_size_i (nodesize_q),
    .merge_en_i  (unit_merge),
    .flags_o     (unit_flags),
    .value_o     (unit_value)
  );

  assign in_stall_o = (state_q != S_IDLE) || mem_busy;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign req_want     = round_pow2(in_data_i.size_blocks);
  assign size_too_big = 32'(in_data_i.size_blocks) > LEAVES;
  assign off_bad      = 32'(in_data_i.offset) >= LEAVES;
  assign leaf_idx     = NW'(in_data_i.offset) + NW'(LEAVES - 1);

  assign half   = nodesize_q >> 1;
  assign lo_kid = left_kid(node_q);
  assign child  = unit_flags.take_left ? lo_kid : lo_kid + NW'(1);

  // Sequencer: one tree level per cycle through the shared node unit.
  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    want_d       = want_q;
    nodesize_d   = nodesize_q;
    node_d       = node_q;
    off_d        = off_q;
    side_d       = side_q;
    wval_d       = wval_q;
    res_off_d    = res_off_q;
    res_status_d = res_status_q;
    rd_a_addr    = '0;
    rd_b_addr    = '0;
    wr_en        = 1'b0;
    wr_addr      = node_q;
    wr_data      = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          cmd_d = in_data_i.command;
          if (in_data_i.command == bba_pkg::CMD_ALLOC) begin
            want_d     = VW'(req_want);
            nodesize_d = VW'(LEAVES);
            node_d     = '0;
            off_d      = '0;
            if (size_too_big) begin
              res_off_d    = '0;
              res_status_d = bba_pkg::STAT_NO_SPACE;
              state_d      = S_RESP;
            end else begin
              rd_a_addr = '0;
              state_d   = S_AROOT;
            end
          end else begin
            nodesize_d = VW'(1);
            node_d     = leaf_idx;
            if (off_bad) begin
              res_off_d    = '0;
              res_status_d = bba_pkg::STAT_BAD_FREE;
              state_d      = S_RESP;
            end else begin
              rd_a_addr = leaf_idx;
              state_d   = S_FCLIMB;
            end
          end
        end
      end
      S_AROOT: begin
        if (rd_a_data < want_q) begin
          res_off_d    = '0;
          res_status_d = bba_pkg::STAT_NO_SPACE;
          state_d      = S_RESP;
        end else if (nodesize_q == want_q) begin
          // The whole pool is taken at once.
          wr_en        = 1'b1;
          wr_addr      = '0;
          wr_data      = '0;
          res_off_d    = '0;
          res_status_d = bba_pkg::STAT_DONE;
          state_d      = S_RESP;
        end else begin
          rd_a_addr = lo_kid;
          rd_b_addr = lo_kid + NW'(1);
          state_d   = S_ADOWN;
        end
      end
      S_ADOWN: begin
        if (!unit_flags.take_left) begin
          off_d = off_q + LW'(half);
        end
        if (half == want_q) begin
          // Mark the chosen node used and start the climb at its parent.
          wr_en     = 1'b1;
          wr_addr   = child;
          wr_data   = '0;
          side_d    = !unit_flags.take_left;
          wval_d    = '0;
          rd_a_addr = lo_kid;
          rd_b_addr = lo_kid + NW'(1);
          state_d   = S_UP;
        end else begin
          node_d     = child;
          nodesize_d = half;
          rd_a_addr  = left_kid(child);
          rd_b_addr  = left_kid(child) + NW'(1);
        end
      end
      S_UP: begin
        wr_en   = 1'b1;
        wr_addr = node_q;
        wr_data = unit_value;
        if (node_q == '0) begin
          res_off_d    = (cmd_q == bba_pkg::CMD_ALLOC) ? off_q : '0;
          res_status_d = bba_pkg::STAT_DONE;
          state_d      = S_RESP;
        end else begin
          node_d     = parent_of(node_q);
          side_d     = !node_q[0];
          wval_d     = unit_value;
          nodesize_d = nodesize_q << 1;
          rd_a_addr  = pair_lo(node_q);
          rd_b_addr  = pair_lo(node_q) + NW'(1);
        end
      end
      S_FCLIMB: begin
        if (rd_a_data == '0) begin
          // Found the allocated node: restore its full size.
          wr_en   = 1'b1;
          wr_addr = node_q;
          wr_data = nodesize_q;
          if (node_q == '0) begin
            res_off_d    = '0;
            res_status_d = bba_pkg::STAT_DONE;
            state_d      = S_RESP;
          end else begin
            node_d     = parent_of(node_q);
            side_d     = !node_q[0];
            wval_d     = nodesize_q;
            nodesize_d = nodesize_q << 1;
            rd_a_addr  = pair_lo(node_q);
            rd_b_addr  = pair_lo(node_q) + NW'(1);
            state_d    = S_UP;
          end
        end else if (node_q == '0) begin
          res_off_d    = '0;
          res_status_d = bba_pkg::STAT_BAD_FREE;
          state_d      = S_RESP;
        end else begin
          node_d     = parent_of(node_q);
          nodesize_d = nodesize_q << 1;
          rd_a_addr  = parent_of(node_q);
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    want_q       <= want_d;
    nodesize_q   <= nodesize_d;
    node_q       <= node_d;
    off_q        <= off_d;
    side_q       <= side_d;
    wval_q       <= wval_d;
    res_off_q    <= res_off_d;
    res_status_q <= res_status_d;
  end

  // Output register: holds a finished transaction while the sequencer takes the next one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_RESP && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_RESP && out_free) begin
      out_q.block_offset <= OffW'(res_off_q);
      out_q.status       <= res_status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A successful allocation is aligned to its rounded size.
  a_alloc_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP && res_status_q == bba_pkg::STAT_DONE && cmd_q == bba_pkg::CMD_ALLOC)
    |-> ((res_off_q & LW'(want_q - VW'(1))) == '0))
    else $error("allocated offset not aligned to the request size");

  // The descent only continues while the current node is larger than the request.
  a_down_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ADOWN) |-> (nodesize_q > want_q))
    else $error("descent past the requested size");

  // The climb only updates inner nodes, never a leaf.
  a_up_inner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UP) |-> (node_q < NW'(LEAVES - 1)))
    else $error("climb updating a leaf node");

  // No request is taken while the clearing pass still runs.
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_busy |-> (in_stall_o && state_q == S_IDLE))
    else $error("request accepted during the clearing pass");

endmodule

`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned LEAVES = bba_pkg::LEAVES_DEFAULT;
  localparam int unsigned NODES = 2 * LEAVES - 1;
  localparam int unsigned SIZE_W = bba_pkg::SIZE_W;
  localparam int unsigned OFF_W = bba_pkg::OFF_W;
  // Nothing is accepted during the clearing pass after reset.
  localparam int WATCHDOG_CYCLES = 10000;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 60;
  localparam int PHASE_ITEMS = 195;
  localparam int MAX_REPORTS = 10;
  localparam int PRED_TREE = 0;
  localparam int GEN_TREE = 1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  bba_pkg::bba_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  bba_pkg::bba_out_t out_data;

  // Largest free run per node: one copy follows accepted transactions, one the stimulus.
  logic [SIZE_W-1:0] free_run [2][NODES];
  bba_pkg::bba_in_t pending_reqs[$];
  bba_pkg::bba_out_t expected_results[$];
  // Runs that the stimulus believes are allocated, as first block and length.
  int live_off[$];
  int live_len[$];

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int sent_count = 0;
  int accepted_count = 0;
  int hold_ticket = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int mismatches = 0;
  int idle_cycles = 0;

  buddy_block_allocator_core #(
    .LEAVES(LEAVES)
  ) u_top (
    .clk_i(clk),
    .rst_ni(rst_n),
    .in_valid_i(in_valid),
    .in_stall_o(in_stall),
    .in_data_i(in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o(out_data)
  );

  always #6 clk = ~clk;

  // Load a tree with its state after reset: leaves hold one, parents twice a child.
  function automatic void tree_reset(input int t);
    for (int i = LEAVES - 1; i < NODES; i++) free_run[t][i] = SIZE_W'(1);
    for (int i = NODES - 1; i > 0; i--) begin
      free_run[t][(i - 1) / 2] = SIZE_W'(free_run[t][i] << 1);
    end
  endfunction

  // Apply one request to a tree and return the result that it gives.
  function automatic bba_pkg::bba_out_t buddy_step(input int t, input bba_pkg::bba_in_t req);
    bba_pkg::bba_out_t res;
    int unsigned want, span, node, sz, lv, rv;
    res.block_offset = '0;
    res.status = bba_pkg::STAT_DONE;
    if (req.command == bba_pkg::CMD_ALLOC) begin
      sz = (req.size_blocks == 0) ? 1 : req.size_blocks;
      want = 1;
      while (want < sz) want <<= 1;
      if (sz > LEAVES || free_run[t][0] < want) begin
        res.status = bba_pkg::STAT_NO_SPACE;
        return res;
      end
      // Descend, taking the left child unless the right one fits and the left does not fit or is larger.
      node = 0;
      span = LEAVES;
      while (span > want) begin
        lv = free_run[t][2 * node + 1];
        rv = free_run[t][2 * node + 2];
        span >>= 1;
        if (rv < want || (want <= lv && lv <= rv)) node = 2 * node + 1;
        else node = 2 * node + 2;
      end
      free_run[t][node] = '0;
      res.block_offset = OFF_W'((node + 1) * span - LEAVES);
      // Ancestors take the larger of their two children.
      while (node != 0) begin
        node = (node - 1) >> 1;
        lv = free_run[t][2 * node + 1];
        rv = free_run[t][2 * node + 2];
        free_run[t][node] = SIZE_W'((lv > rv) ? lv : rv);
      end
    end else begin
      if (req.offset >= LEAVES) begin
        res.status = bba_pkg::STAT_BAD_FREE;
        return res;
      end
      // Climb from the leaf to the allocated node, which holds zero.
      span = 1;
      node = req.offset + LEAVES - 1;
      while (free_run[t][node] != 0) begin
        if (node == 0) begin
          res.status = bba_pkg::STAT_BAD_FREE;
          return res;
        end
        span <<= 1;
        node = (node - 1) >> 1;
      end
      free_run[t][node] = SIZE_W'(span);
      // Merge buddies that are both entirely free on the way back to the root.
      while (node != 0) begin
        node = (node - 1) >> 1;
        span <<= 1;
        lv = free_run[t][2 * node + 1];
        rv = free_run[t][2 * node + 2];
        free_run[t][node] = SIZE_W'((lv + rv == span) ? span : ((lv > rv) ? lv : rv));
      end
    end
    return res;
  endfunction

  // Queue one request and keep the list of live runs in step with it.
  task automatic push_req(input bba_pkg::bba_cmd_e cmd, input int size, input int off);
    bba_pkg::bba_in_t req;
    bba_pkg::bba_out_t res;
    int want;
    int hit;
    req.command = cmd;
    req.size_blocks = SIZE_W'(size);
    req.offset = OFF_W'(off);
    res = buddy_step(GEN_TREE, req);
    hit = -1;
    if (res.status == bba_pkg::STAT_DONE && cmd == bba_pkg::CMD_ALLOC) begin
      want = 1;
      while (want < size) want <<= 1;
      live_off.push_back(res.block_offset);
      live_len.push_back(want);
    end else if (res.status == bba_pkg::STAT_DONE) begin
      for (int i = 0; i < live_off.size(); i++) begin
        if (hit < 0 && off >= live_off[i] && off < live_off[i] + live_len[i]) hit = i;
      end
      if (hit >= 0) begin
        live_off.delete(hit);
        live_len.delete(hit);
      end
    end
    pending_reqs.push_back(req);
  endtask

  // Mostly frees of live runs and allocations of small sizes, with some noise.
  task automatic push_random(input int alloc_pct);
    int k;
    int sel;
    int size;
    sel = $urandom_range(99);
    if (live_off.size() != 0 && sel >= alloc_pct) begin
      if ($urandom_range(19) == 0) begin
        push_req(bba_pkg::CMD_FREE, $urandom_range(2047), $urandom_range(LEAVES - 1));
      end else begin
        k = $urandom_range(live_off.size() - 1);
        push_req(bba_pkg::CMD_FREE, $urandom_range(2047),
                 live_off[k] + $urandom_range(live_len[k] - 1));
      end
    end else begin
      sel = $urandom_range(99);
      if (sel < 60) size = $urandom_range(8);
      else if (sel < 85) size = $urandom_range(64, 9);
      else if (sel < 95) size = $urandom_range(LEAVES, 65);
      else size = $urandom_range(2047, LEAVES + 1);
      push_req(bba_pkg::CMD_ALLOC, size, $urandom_range(LEAVES - 1));
    end
  endtask

  // Wait until every queued request is accepted and every result has come back.
  task automatic wait_drained;
    @(negedge clk);
    while (pending_reqs.size() != 0 || accepted_count != sent_count ||
           expected_results.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int n);
    int alloc_pct;
    tx_idle_pct = idle_pct;
    rx_stall_pct = stall_pct;
    alloc_pct = 50;
    for (int i = 0; i < n; i++) begin
      if (i % 50 == 0) alloc_pct = $urandom_range(85, 30);
      push_random(alloc_pct);
    end
    wait_drained();
  endtask

  // Sequence of the run: reset, directed requests, then random phases.
  initial begin
    tree_reset(PRED_TREE);
    tree_reset(GEN_TREE);
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Whole pool, full pool, free from inside the run, then a double free.
    push_req(bba_pkg::CMD_ALLOC, 1024, $urandom_range(LEAVES - 1));
    push_req(bba_pkg::CMD_ALLOC, 0, $urandom_range(LEAVES - 1));
    push_req(bba_pkg::CMD_FREE, 2047, 517);
    push_req(bba_pkg::CMD_FREE, 0, 517);
    // Zero counts as one, sizes round up, oversized requests are refused.
    push_req(bba_pkg::CMD_ALLOC, 0, 1023);
    push_req(bba_pkg::CMD_ALLOC, 1, 0);
    push_req(bba_pkg::CMD_ALLOC, 3, $urandom_range(LEAVES - 1));
    push_req(bba_pkg::CMD_ALLOC, 2047, $urandom_range(LEAVES - 1));
    push_req(bba_pkg::CMD_ALLOC, 1025, $urandom_range(LEAVES - 1));
    push_req(bba_pkg::CMD_ALLOC, 513, $urandom_range(LEAVES - 1));
    push_req(bba_pkg::CMD_ALLOC, 512, $urandom_range(LEAVES - 1));
    push_req(bba_pkg::CMD_FREE, 1024, 1023);
    push_req(bba_pkg::CMD_FREE, 1, 1023);
    push_req(bba_pkg::CMD_FREE, 5, 6);
    push_req(bba_pkg::CMD_FREE, 0, 0);
    push_req(bba_pkg::CMD_FREE, 0, 1);
    // The right child is chosen when it fits and is strictly smaller.
    push_req(bba_pkg::CMD_ALLOC, 2, 0);
    push_req(bba_pkg::CMD_ALLOC, 1, 0);
    push_req(bba_pkg::CMD_FREE, 0, 0);
    push_req(bba_pkg::CMD_ALLOC, 1, 0);
    push_req(bba_pkg::CMD_FREE, 0, 2);
    push_req(bba_pkg::CMD_FREE, 0, 3);
    push_req(bba_pkg::CMD_ALLOC, 1024, 0);
    push_req(bba_pkg::CMD_FREE, 2047, 1023);
    wait_drained();

    run_phase(0, 0, PHASE_ITEMS);
    run_phase(82, 0, PHASE_ITEMS);
    run_phase(0, 82, PHASE_ITEMS);
    run_phase(26, 26, PHASE_ITEMS);
    // Long receiver hold-off while the sender keeps offering.
    hold_ticket++;
    run_phase(0, 0, 20);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Request driver: holds a stalled transaction, otherwise offers the next or idles.
  always @(negedge clk) begin
    bba_pkg::bba_in_t next_req;
    logic next_valid;
    next_req = in_data;
    next_valid = in_valid;
    if (!in_valid || accepted_count == sent_count) begin
      next_valid = 1'b0;
      if (pending_reqs.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        next_req = pending_reqs.pop_front();
        next_valid = 1'b1;
        sent_count++;
      end
    end
    in_valid <= next_valid;
    in_data <= next_req;
  end

  // Result receiver: random stalls, plus a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_seen != hold_ticket) begin
      hold_seen = hold_ticket;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // Predict accepted requests, check returned results, and watch for a hang.
  always @(posedge clk) begin
    bba_pkg::bba_out_t exp_res;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(buddy_step(PRED_TREE, in_data));
        accepted_count++;
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("unexpected result: offset %0d status %0d",
                     out_data.block_offset, out_data.status);
          end
        end else begin
          exp_res = expected_results.pop_front();
          if (out_data.block_offset != exp_res.block_offset ||
              out_data.status != exp_res.status) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display({"result mismatch: expected offset %0d status %0d, ",
                        "got offset %0d status %0d"},
                       exp_res.block_offset, exp_res.status,
                       out_data.block_offset, out_data.status);
            end
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

endmodule
